### design/cpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpsd_pkg;

    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int ADDR_W  = 20;
    localparam int COLOR_W = 8;
    localparam int COLORS  = 256;

    localparam logic [1:0] REG_REMAP_OFFSET = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [COLOR_W-1:0] RESET_REMAP_OFFSET = 8'd0;
    localparam logic [SIZE_W-1:0]  RESET_IMAGE_WIDTH  = 11'd64;
    localparam logic [SIZE_W-1:0]  RESET_IMAGE_HEIGHT = 11'd128;

    localparam logic [COLOR_W-1:0] COLUMN_END    = 8'hFF;
    localparam logic [3:0]         REMAP_NIBBLE  = 4'h7;

    typedef struct packed {
        logic [COLOR_W-1:0] remap_offset;
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
    } cpsd_cfg_t;

    typedef struct packed {
        logic               is_pixel;
        logic               bad;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
    } cpsd_op_t;

    typedef struct packed {
        logic               pixel_valid;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               first_use;
        logic               column_done;
        logic               bad_post;
    } cpsd_result_t;

endpackage

`default_nettype wire

### design/cpsd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cpsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/cpsd_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cpsd_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cpsd_pkg::cpsd_cfg_t cfg
);

    import cpsd_pkg::*;

    cpsd_cfg_t  cfg_reg, cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_REMAP_OFFSET: cfg_next.remap_offset = pwdata[COLOR_W-1:0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[SIZE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_REMAP_OFFSET: prdata = {24'd0, cfg_reg.remap_offset};
            REG_IMAGE_WIDTH:  prdata = {21'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT: prdata = {21'd0, cfg_reg.image_height};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.remap_offset <= RESET_REMAP_OFFSET;
            cfg_reg.image_width  <= RESET_IMAGE_WIDTH;
            cfg_reg.image_height <= RESET_IMAGE_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### design/cpsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cpsd_front #(
    parameter int COLUMN_LIMIT = 512
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [cpsd_pkg::COLOR_W-1:0]   column_byte,
    input  wire logic [cpsd_pkg::COORD_W-1:0]   column_index,
    input  wire logic                           column_start,
    output logic                                op_push,
    output cpsd_pkg::cpsd_op_t                  op
);

    import cpsd_pkg::*;

    localparam int POS_W = $clog2(COLUMN_LIMIT + 1);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(COLUMN_LIMIT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(COLUMN_LIMIT - 1);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ROW   = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_PAD1  = 3'd3;
    localparam logic [2:0] PH_PIX   = 3'd4;
    localparam logic [2:0] PH_PAD2  = 3'd5;

    logic [2:0]         phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [7:0]         left_reg, left_next;
    logic [2:0]         phase_cur;
    logic [POS_W-1:0]   pos_cur;
    logic [POS_W-1:0]   pos_inc;
    logic [7:0]         left_dec;

    assign phase_cur = column_start ? PH_ROW : phase_reg;
    assign pos_cur   = column_start ? '0 : pos_reg;
    assign pos_inc   = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 1'b1;
    assign left_dec  = left_reg - 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        op_push    = 1'b0;
        op         = '0;
        if (accept)
        begin
            unique case (phase_cur)
                PH_ROW:
                begin
                    pos_next = pos_inc;
                    if (column_byte == COLUMN_END)
                    begin
                        op_push    = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else if (pos_cur >= POS_LAST)
                    begin
                        op_push    = 1'b1;
                        op.bad     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        row_next   = {2'b00, column_byte};
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    pos_next   = pos_inc;
                    left_next  = column_byte;
                    phase_next = PH_PAD1;
                end
                PH_PAD1:
                begin
                    pos_next   = pos_inc;
                    phase_next = (left_reg != '0) ? PH_PIX : PH_PAD2;
                end
                PH_PAD2:
                begin
                    pos_next   = pos_inc;
                    phase_next = PH_ROW;
                end
                PH_PIX:
                begin
                    pos_next    = pos_inc;
                    op_push     = 1'b1;
                    op.is_pixel = 1'b1;
                    op.x        = column_index;
                    op.y        = row_reg;
                    op.color    = column_byte;
                    row_next    = row_reg + 1'b1;
                    left_next   = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_PAD2;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            row_reg   <= row_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

### design/cpsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cpsd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 go,
    input  wire cpsd_pkg::cpsd_op_t   op,
    input  wire cpsd_pkg::cpsd_cfg_t  cfg,
    output cpsd_pkg::cpsd_result_t    result
);

    import cpsd_pkg::*;

    logic [COLORS-1:0]            used_reg, used_next;
    logic [COLOR_W-1:0]           color;
    logic                         in_range;
    logic [COORD_W+SIZE_W-1:0]    product;
    logic [ADDR_W-1:0]            address;

    always_comb
    begin
        color = op.color;
        if (cfg.remap_offset != '0 && op.color[7:4] == REMAP_NIBBLE)
        begin
            color = op.color + cfg.remap_offset;
        end
    end

    assign in_range = ({1'b0, op.y} < cfg.image_height) && ({1'b0, op.x} < cfg.image_width);
    assign product  = {{SIZE_W{1'b0}}, op.y} * {{COORD_W{1'b0}}, cfg.image_width};
    assign address  = product[ADDR_W-1:0] + {{(ADDR_W-COORD_W){1'b0}}, op.x};

    always_comb
    begin
        result    = '0;
        used_next = used_reg;
        if (op.is_pixel)
        begin
            result.pixel_x     = op.x;
            result.pixel_y     = op.y;
            result.pixel_color = color;
            if (in_range)
            begin
                result.pixel_valid   = 1'b1;
                result.pixel_address = address;
                result.first_use     = !used_reg[color];
                if (go)
                begin
                    used_next[color] = 1'b1;
                end
            end
            else
            begin
                result.bad_post = 1'b1;
            end
        end
        else
        begin
            result.column_done = 1'b1;
            result.bad_post    = op.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= {{(COLORS-1){1'b0}}, 1'b1};
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

`default_nettype wire

### design/column_post_sprite_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Column post decoder for sprite pictures. Column bytes arrive through a queue-style
// input: a transaction is taken when push is high and full is low. Pixel results and
// column-end results leave through a queue-style output: the oldest result is on the
// result ports while empty is low and is taken when pop is high.
// One byte is taken in every cycle while full is low. A byte that gives a result is
// written by the parser to a short operation queue at the edge that takes it; the pixel
// unit (remap, bounds check, one frame address multiply and the used-colour set) then
// moves it into the two-entry result queue whenever that queue has room. Count and pad
// bytes give no result, nor does a row byte that opens a post. When the receiver stops
// popping, the result queue fills, the pixel unit stops draining the operation queue,
// and full rises once that queue is full too; nothing is lost. Configuration registers
// are to be written through the APB port while the block is idle; the block does not
// enforce this. Reset empties both queues, returns the parser to waiting for a column
// start, loads the register defaults and clears the used-colour set except for colour zero.
module column_post_sprite_decoder #(
    parameter int COLUMN_LIMIT = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [cpsd_pkg::COLOR_W-1:0]  column_byte,
    input  wire logic [cpsd_pkg::COORD_W-1:0]  column_index,
    input  wire logic                          column_start,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               pixel_valid,
    output logic [cpsd_pkg::COORD_W-1:0]       pixel_x,
    output logic [cpsd_pkg::COORD_W-1:0]       pixel_y,
    output logic [cpsd_pkg::ADDR_W-1:0]        pixel_address,
    output logic [cpsd_pkg::COLOR_W-1:0]       pixel_color,
    output logic                               first_use,
    output logic                               column_done,
    output logic                               bad_post
);

    import cpsd_pkg::*;

    cpsd_cfg_t    cfg;
    cpsd_op_t     op_in;
    cpsd_op_t     op_out;
    cpsd_result_t result_in;
    cpsd_result_t result_out;
    logic         accept;
    logic         op_push;
    logic         op_full;
    logic         op_empty;
    logic         res_full;
    logic         go;

    assign full   = op_full;
    assign accept = push && !op_full;
    assign go     = !op_empty && !res_full;

    cpsd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpsd_front #(
        .COLUMN_LIMIT (COLUMN_LIMIT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .column_byte  (column_byte),
        .column_index (column_index),
        .column_start (column_start),
        .op_push      (op_push),
        .op           (op_in)
    );

    cpsd_fifo #(
        .WIDTH ($bits(cpsd_op_t)),
        .DEPTH (2)
    ) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_data (op_in),
        .full      (op_full),
        .pop       (go),
        .pop_data  (op_out),
        .empty     (op_empty)
    );

    cpsd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .op     (op_out),
        .cfg    (cfg),
        .result (result_in)
    );

    cpsd_fifo #(
        .WIDTH ($bits(cpsd_result_t)),
        .DEPTH (2)
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (go),
        .push_data (result_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (result_out),
        .empty     (empty)
    );

    assign pixel_valid   = result_out.pixel_valid;
    assign pixel_x       = result_out.pixel_x;
    assign pixel_y       = result_out.pixel_y;
    assign pixel_address = result_out.pixel_address;
    assign pixel_color   = result_out.pixel_color;
    assign first_use     = result_out.first_use;
    assign column_done   = result_out.column_done;
    assign bad_post      = result_out.bad_post;

endmodule

`default_nettype wire
